// File: rtl/bfei_pkg.sv
package bfei_pkg;

  localparam int MEM_BYTES_DEF = 1024;
  localparam int OFF_W         = 13;
  localparam int WID_W         = 6;
  localparam int VAL_W         = 32;
  localparam int WIN_W         = 40;
  localparam int SH_W          = 6;
  localparam int BIDX_W        = 11;
  localparam int BCNT_W        = 3;

  localparam logic [WID_W-1:0] FIELD_MAX = 6'd32;

  typedef enum logic {
    CMD_READ  = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_WIDTH = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic {
    SHIFT_LEFT  = 1'b0,
    SHIFT_RIGHT = 1'b1
  } shift_dir_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PREP_M,
    S_PREP_V,
    S_RUN,
    S_FINISH
  } state_t;

  function automatic logic [VAL_W-1:0] field_mask(input logic [WID_W-1:0] w);
    logic [VAL_W-1:0] m;
    if (w >= FIELD_MAX) begin
      m = '1;
    end else begin
      m = (VAL_W'(1) << w) - VAL_W'(1);
    end
    return m;
  endfunction

  function automatic logic [SH_W-1:0] byte_top(input logic [BCNT_W-1:0] k);
    return SH_W'(WIN_W - 1) - {k, 3'b000};
  endfunction

endpackage

// File: rtl/bitfield_extract_insert_core.sv
// Bit-field extract/insert over a MEM_BYTES byte store, bits numbered MSB-first
// from byte 0. One command is taken at a time: a field touching n bytes (n = 1..5;
// a zero-width field off a byte boundary still reads its one byte) has its bytes
// read in turn; a zero-width field on a byte boundary and a command rejected for
// width or range read no byte. The single byte-wide memory is read (and on a
// write, rewritten) one byte per cycle, and one shared 40-bit shifter is used for
// mask and write-value alignment and for result extraction. After reset the store
// is cleared in a pass over all MEM_BYTES bytes, during which in_stall stays high.
module bitfield_extract_insert_core #(
  parameter int MEM_BYTES = bfei_pkg::MEM_BYTES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_cmd,
  input  logic [bfei_pkg::OFF_W-1:0] in_bit_offset,
  input  logic [bfei_pkg::WID_W-1:0] in_field_width,
  input  logic [bfei_pkg::VAL_W-1:0] in_write_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [bfei_pkg::VAL_W-1:0] out_read_value,
  output logic [1:0]                 out_status
);
  import bfei_pkg::*;

  localparam int AW = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;
  localparam int TB_W = ((AW + 4) > (OFF_W + 1)) ? (AW + 4) : (OFF_W + 1);
  localparam logic [TB_W-1:0] TOTAL_BITS = TB_W'(MEM_BYTES * 8);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MEM_BYTES - 1);

  state_t state_r, state_nxt;

  logic             cmd_r, cmd_nxt;
  logic [OFF_W-1:0] off_r, off_nxt;
  logic [WID_W-1:0] w_r, w_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  logic [1:0]       status_r, status_nxt;
  logic [BCNT_W-1:0] n_r, n_nxt;
  logic [WIN_W-1:0] mask_r, mask_nxt;
  logic [WIN_W-1:0] vbits_r, vbits_nxt;
  logic [WIN_W-1:0] win_r, win_nxt;
  logic [BCNT_W-1:0] rk_r, rk_nxt;
  logic [BCNT_W-1:0] wk_r, wk_nxt;
  logic             rpend_r, rpend_nxt;
  logic [AW-1:0]    clr_addr_r, clr_addr_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0] out_read_value_r, out_read_value_nxt;
  logic [1:0]       out_status_r, out_status_nxt;

  logic [2:0]       s;
  logic [SH_W-1:0]  sh;
  logic [1:0]       status_c;
  logic [BCNT_W-1:0] n_c;
  logic [TB_W-1:0]  field_end;
  logic             accept;
  logic             out_free;
  logic             last_byte;

  logic             shf_dir_left;
  shift_dir_t       shf_dir;
  logic [WIN_W-1:0] shf_in, shf_out;

  logic             wr_en, rd_en;
  logic [AW-1:0]    wr_addr, rd_addr;
  logic [7:0]       wr_data, rd_data;
  logic [7:0]       old_byte, mk, vk;
  logic [BIDX_W-1:0] rd_idx, wr_idx;
  logic [SH_W-1:0]  wtop;

  bfei_shift u_shift (
    .data   (shf_in),
    .amt    (sh),
    .dir    (shf_dir),
    .result (shf_out)
  );

  bfei_mem #(
    .DEPTH (MEM_BYTES),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign s         = off_r[2:0];
  assign sh        = SH_W'(WIN_W) - SH_W'(s) - w_r;
  assign field_end = TB_W'(off_r) + TB_W'(w_r);
  assign n_c       = BCNT_W'((WID_W'(s) + w_r + WID_W'(7)) >> 3);
  assign last_byte = rpend_r && (wk_r == n_r - BCNT_W'(1));
  assign rd_idx    = BIDX_W'(off_r[OFF_W-1:3]) + BIDX_W'(rk_r);
  assign wr_idx    = BIDX_W'(off_r[OFF_W-1:3]) + BIDX_W'(wk_r);
  assign wtop      = byte_top(wk_r);
  assign old_byte  = rd_data;
  assign mk        = mask_r[wtop -: 8];
  assign vk        = vbits_r[wtop -: 8];
  assign shf_dir_left = (state_r == S_PREP_M) || (state_r == S_PREP_V);
  assign shf_dir   = shf_dir_left ? SHIFT_LEFT : SHIFT_RIGHT;

  always_comb begin
    if (w_r > FIELD_MAX) begin
      status_c = ST_WIDTH;
    end else if (field_end > TOTAL_BITS) begin
      status_c = ST_RANGE;
    end else begin
      status_c = ST_OK;
    end
  end

  always_comb begin
    case (state_r)
      S_PREP_M: shf_in = {8'b0, field_mask(w_r)};
      S_PREP_V: shf_in = {8'b0, val_r & field_mask(w_r)};
      default:  shf_in = win_r;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_addr_r == LAST_ADDR) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) state_nxt = S_PREP_M;
      end
      S_PREP_M: begin
        state_nxt = (status_c == ST_OK) ? S_PREP_V : S_FINISH;
      end
      S_PREP_V: begin
        state_nxt = (n_r == '0) ? S_FINISH : S_RUN;
      end
      S_RUN: begin
        if (last_byte) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_nxt            = cmd_r;
    off_nxt            = off_r;
    w_nxt              = w_r;
    val_nxt            = val_r;
    status_nxt         = status_r;
    n_nxt              = n_r;
    mask_nxt           = mask_r;
    vbits_nxt          = vbits_r;
    win_nxt            = win_r;
    rk_nxt             = rk_r;
    wk_nxt             = wk_r;
    rpend_nxt          = 1'b0;
    clr_addr_nxt       = clr_addr_r;
    out_valid_nxt      = out_valid_r && out_stall;
    out_read_value_nxt = out_read_value_r;
    out_status_nxt     = out_status_r;
    wr_en              = 1'b0;
    wr_addr            = AW'({{AW{1'b0}}, wr_idx});
    wr_data            = (old_byte & ~mk) | (vk & mk);
    rd_en              = 1'b0;
    rd_addr            = AW'({{AW{1'b0}}, rd_idx});
    case (state_r)
      S_CLEAR: begin
        wr_en        = 1'b1;
        wr_addr      = clr_addr_r;
        wr_data      = 8'h00;
        clr_addr_nxt = clr_addr_r + AW'(1);
      end
      S_IDLE: begin
        if (accept) begin
          cmd_nxt = in_cmd;
          off_nxt = in_bit_offset;
          w_nxt   = in_field_width;
          val_nxt = in_write_value;
        end
      end
      S_PREP_M: begin
        status_nxt = status_c;
        n_nxt      = n_c;
        mask_nxt   = shf_out;
      end
      S_PREP_V: begin
        vbits_nxt = shf_out;
        win_nxt   = '0;
        rk_nxt    = '0;
      end
      S_RUN: begin
        if (rk_r < n_r) begin
          rd_en  = 1'b1;
          rk_nxt = rk_r + BCNT_W'(1);
        end
        rpend_nxt = rd_en;
        wk_nxt    = rk_r;
        if (rpend_r) begin
          win_nxt[wtop -: 8] = old_byte;
          wr_en = (cmd_r == CMD_WRITE);
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          if (cmd_r == CMD_READ && status_r == ST_OK) begin
            out_read_value_nxt = shf_out[VAL_W-1:0] & field_mask(w_r);
          end else begin
            out_read_value_nxt = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      rpend_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      rpend_r     <= rpend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r            <= cmd_nxt;
    off_r            <= off_nxt;
    w_r              <= w_nxt;
    val_r            <= val_nxt;
    status_r         <= status_nxt;
    n_r              <= n_nxt;
    mask_r           <= mask_nxt;
    vbits_r          <= vbits_nxt;
    win_r            <= win_nxt;
    rk_r             <= rk_nxt;
    wk_r             <= wk_nxt;
    out_read_value_r <= out_read_value_nxt;
    out_status_r     <= out_status_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_read_value_r;
  assign out_status     = out_status_r;

  a_write_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && state_r == S_RUN) |-> (cmd_r == CMD_WRITE && status_r == ST_OK))
    else $error("memory written by a read or failed command");

  a_rd_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> (rk_r <= n_r))
    else $error("byte read count past field span");

  a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_FINISH))
    else $error("result raised outside finish");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> (out_read_value_r == '0))
    else $error("nonzero value with error status");

endmodule

// File: rtl/bfei_mem.sv
module bfei_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/bfei_shift.sv
module bfei_shift (
  input  logic [bfei_pkg::WIN_W-1:0] data,
  input  logic [bfei_pkg::SH_W-1:0]  amt,
  input  bfei_pkg::shift_dir_t       dir,
  output logic [bfei_pkg::WIN_W-1:0] result
);
  import bfei_pkg::*;

  always_comb begin
    case (dir)
      SHIFT_LEFT:  result = data << amt;
      SHIFT_RIGHT: result = data >> amt;
      default:     result = data;
    endcase
  end

endmodule
